// ===== design/ofc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofc_pkg
// Shared types, constants and saturation helpers for the outgoing flux clamp.
// ----------------------------------------------------------------------------
package ofc_pkg;
  localparam int DIM_DEFAULT = 3;
  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int NFACES = 6;
  localparam int FRAC_W = 17;
  localparam int OSUM_W = 32;
  localparam int OVER_W = 49;
  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [2:0] {
    REG_TIME_STEP = 3'd0,
    REG_INV_DX_X  = 3'd1,
    REG_INV_DX_Y  = 3'd2,
    REG_INV_DX_Z  = 3'd3,
    REG_FLOOR     = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] cell_value;
    logic signed [31:0] flux_lo_x;
    logic signed [31:0] flux_hi_x;
    logic signed [31:0] flux_lo_y;
    logic signed [31:0] flux_hi_y;
    logic signed [31:0] flux_lo_z;
    logic signed [31:0] flux_hi_z;
    logic [5:0]         neumann_faces;
  } cell_beat_t;

  typedef struct packed {
    logic [FRAC_W-1:0]  overshoot_fraction;
    logic signed [31:0] delta_lo_x;
    logic signed [31:0] delta_hi_x;
    logic signed [31:0] delta_lo_y;
    logic signed [31:0] delta_hi_y;
    logic signed [31:0] delta_lo_z;
    logic signed [31:0] delta_hi_z;
    logic [5:0]         delta_written;
    logic signed [31:0] rhs_adjust;
  } result_beat_t;

  typedef struct packed {
    logic [30:0]        time_step;
    logic [30:0]        inv_dx_x;
    logic [30:0]        inv_dx_y;
    logic [30:0]        inv_dx_z;
    logic signed [31:0] floor_value;
  } cfg_t;

  function automatic logic [31:0] vmax(input int satw);
    vmax = (32'd1 << (satw - 1)) - 32'd1;
  endfunction

  // saturate magnitude product (>>16) to vmax
  function automatic logic [31:0] magsat(input logic [63:0] p, input int satw);
    logic [63:0] s;
    logic [31:0] m;
    s = p >> 16;
    m = vmax(satw);
    magsat = (s > {32'd0, m}) ? m : s[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== design/ofc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofc_if
// Valid/ready channel carrying one beat of payload.
// ----------------------------------------------------------------------------
interface ofc_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/outgoing_flux_clamp_cell_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// outgoing_flux_clamp_cell_core
// Outgoing flux clamp: sums outgoing face flux, derives the overshoot
// fraction and the per-face flux corrections and right-hand-side term.
// Accepts one cell per cycle unless the result output stalls.
// The quotient pipeline has 17 stages; a stall freezes all stages.
// Reset clears all valid bits and loads register defaults (dx inverses one).
// ----------------------------------------------------------------------------
module outgoing_flux_clamp_cell_core import ofc_pkg::*; #(
  parameter int DIM = DIM_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  ofc_if.sink              cells,
  ofc_if.source            result
);
  localparam int SATW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam logic [31:0] VMAX = (32'd1 << (SATW - 1)) - 32'd1;
  localparam logic signed [33:0] SVMAX = $signed({2'b00, VMAX});
  localparam logic signed [33:0] SVMIN = -SVMAX - 34'sd1;

  cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step <= '0;
      cfg.inv_dx_x <= 31'd65536;
      cfg.inv_dx_y <= 31'd65536;
      cfg.inv_dx_z <= 31'd65536;
      cfg.floor_value <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP: cfg.time_step <= cfg_data[30:0];
        REG_INV_DX_X:  cfg.inv_dx_x <= cfg_data[30:0];
        REG_INV_DX_Y:  cfg.inv_dx_y <= cfg_data[30:0];
        REG_INV_DX_Z:  cfg.inv_dx_z <= cfg_data[30:0];
        REG_FLOOR:     cfg.floor_value <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [30:0] inv_of(input int f, input cfg_t c);
    case (f >> 1)
      0: inv_of = c.inv_dx_x;
      1: inv_of = c.inv_dx_y;
      default: inv_of = c.inv_dx_z;
    endcase
  endfunction

  // output skid: result register
  logic         out_v;
  result_beat_t out_d;
  logic         en;
  assign en = !out_v || result.ready;
  assign cells.ready = en;
  assign result.valid = out_v;
  assign result.data = out_d;

  // stage 1: magnitudes, outgoing flags, A = dt*|flux|
  logic               s1_v;
  logic signed [31:0] s1_cell;
  logic [5:0]         s1_nm, s1_out, s1_neg;
  logic [31:0]        s1_mag [NFACES];
  logic [31:0]        s1_a [NFACES];
  logic signed [31:0] fl [NFACES];
  assign fl[0] = cells.data.flux_lo_x; assign fl[1] = cells.data.flux_hi_x;
  assign fl[2] = cells.data.flux_lo_y; assign fl[3] = cells.data.flux_hi_y;
  assign fl[4] = cells.data.flux_lo_z; assign fl[5] = cells.data.flux_hi_z;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= cells.valid;
    if (en) begin
      s1_cell <= cells.data.cell_value;
      s1_nm <= cells.data.neumann_faces;
      for (int f = 0; f < NFACES; f++) begin
        logic [31:0] m;
        logic        o;
        m = fl[f][31] ? 32'(-fl[f]) : 32'(fl[f]);
        o = ((f >> 1) < DIM) && ((f & 1) != 0 ? (fl[f] > 0) : fl[f][31]);
        s1_mag[f] <= m;
        s1_out[f] <= o;
        s1_neg[f] <= fl[f][31];
        s1_a[f] <= magsat({33'd0, cfg.time_step} * {32'd0, m}, SATW);
      end
    end
  end

  // stage 2: term = A*inv_dx
  logic               s2_v;
  logic signed [31:0] s2_cell;
  logic [5:0]         s2_nm, s2_out, s2_neg;
  logic [31:0]        s2_mag [NFACES];
  logic [31:0]        s2_t [NFACES];
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
    if (en) begin
      s2_cell <= s1_cell; s2_nm <= s1_nm; s2_out <= s1_out; s2_neg <= s1_neg;
      for (int f = 0; f < NFACES; f++) begin
        s2_mag[f] <= s1_mag[f];
        s2_t[f] <= s1_out[f] ?
          magsat({32'd0, s1_a[f]} * {33'd0, inv_of(f, cfg)}, SATW) : 32'd0;
      end
    end
  end

  // stage 3: saturating sum (terms nonnegative, so clamp at end is equal)
  logic               s3_v;
  logic signed [31:0] s3_cell;
  logic [5:0]         s3_nm, s3_out, s3_neg;
  logic [31:0]        s3_mag [NFACES];
  logic [31:0]        s3_o;
  always_ff @(posedge clk) begin
    logic [34:0] acc;
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
    if (en) begin
      acc = '0;
      for (int f = 0; f < NFACES; f++) acc = acc + {3'd0, s2_t[f]};
      s3_o <= (acc > {3'd0, VMAX}) ? VMAX : acc[31:0];
      s3_cell <= s2_cell; s3_nm <= s2_nm; s3_out <= s2_out; s3_neg <= s2_neg;
      for (int f = 0; f < NFACES; f++) s3_mag[f] <= s2_mag[f];
    end
  end

  // stage 4: classify and form numerator
  typedef struct packed {
    logic [5:0]         nm;
    logic [5:0]         outg;
    logic [5:0]         neg;
    logic [NFACES*32-1:0] mag;
  } tag_t;
  logic              s4_v, s4_do;
  logic [OVER_W-1:0] s4_num;
  logic [31:0]       s4_den;
  logic [FRAC_W-1:0] s4_frac;
  tag_t              s4_tag;
  always_ff @(posedge clk) begin
    logic signed [33:0] after, over;
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= s3_v;
    if (en) begin
      after = 34'(s3_cell) - $signed({2'b00, s3_o});
      over = 34'(cfg.floor_value) - after;
      s4_den <= s3_o;
      s4_num <= {over[32:0], 16'd0};
      s4_tag.nm <= s3_nm; s4_tag.outg <= s3_out; s4_tag.neg <= s3_neg;
      for (int f = 0; f < NFACES; f++) s4_tag.mag[f*32 +: 32] <= s3_mag[f];
      if (s3_cell <= cfg.floor_value) begin
        s4_do <= 1'b0; s4_frac <= ONE_Q16;
      end else if (after >= 34'(cfg.floor_value) || s3_o == '0) begin
        s4_do <= 1'b0; s4_frac <= '0;
      end else begin
        s4_do <= 1'b1; s4_frac <= '0;
      end
    end
  end

  logic              dv;
  logic [FRAC_W-1:0] dfrac;
  tag_t              dtag;
  ofc_div #(.tag_t(tag_t)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(s4_v), .in_do(s4_do),
    .in_num(s4_num), .in_den(s4_den), .in_frac(s4_frac), .in_tag(s4_tag),
    .out_valid(dv), .out_frac(dfrac), .out_tag(dtag)
  );

  // stage 5: m = frac*|flux|>>16, deltas
  logic               s5_v;
  logic [FRAC_W-1:0]  s5_frac;
  logic [5:0]         s5_nm, s5_out, s5_wr;
  logic [31:0]        s5_m [NFACES];
  logic signed [31:0] s5_d [NFACES];
  always_ff @(posedge clk) begin
    logic [48:0] p;
    logic [32:0] m;
    logic signed [33:0] dd;
    if (rst) s5_v <= 1'b0;
    else if (en) s5_v <= dv;
    if (en) begin
      s5_frac <= dfrac; s5_nm <= dtag.nm; s5_out <= dtag.outg;
      for (int f = 0; f < NFACES; f++) begin
        p = {32'd0, dfrac} * {17'd0, dtag.mag[f*32 +: 32]};
        m = p[48:16];
        s5_m[f] <= m[31:0];
        dd = dtag.neg[f] ? $signed({1'b0, m}) : -$signed({1'b0, m});
        if (dd > SVMAX) dd = SVMAX;
        if (dd < SVMIN) dd = SVMIN;
        s5_wr[f] <= (dfrac != '0) && dtag.outg[f] && !dtag.nm[f];
        s5_d[f] <= ((dfrac != '0) && dtag.outg[f] && !dtag.nm[f]) ? dd[31:0] : 32'sd0;
      end
    end
  end

  // stage 6: neumann terms
  logic               s6_v;
  logic [FRAC_W-1:0]  s6_frac;
  logic [5:0]         s6_wr;
  logic signed [31:0] s6_d [NFACES];
  logic [31:0]        s6_t [NFACES];
  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (en) s6_v <= s5_v;
    if (en) begin
      s6_frac <= s5_frac; s6_wr <= s5_wr;
      for (int f = 0; f < NFACES; f++) begin
        s6_d[f] <= s5_d[f];
        s6_t[f] <= ((s5_frac != '0) && s5_out[f] && s5_nm[f]) ?
          magsat({32'd0, s5_m[f]} * {33'd0, inv_of(f, cfg)}, SATW) : 32'd0;
      end
    end
  end

  // final: saturating rhs (terms all subtract, clamp at end is equal)
  always_ff @(posedge clk) begin
    logic signed [35:0] r;
    if (rst) out_v <= 1'b0;
    else if (en) out_v <= s6_v;
    if (en) begin
      r = '0;
      for (int f = 0; f < NFACES; f++) r = r - $signed({4'd0, s6_t[f]});
      if (r < 36'(SVMIN)) r = 36'(SVMIN);
      out_d.overshoot_fraction <= s6_frac;
      out_d.delta_lo_x <= s6_d[0]; out_d.delta_hi_x <= s6_d[1];
      out_d.delta_lo_y <= s6_d[2]; out_d.delta_hi_y <= s6_d[3];
      out_d.delta_lo_z <= s6_d[4]; out_d.delta_hi_z <= s6_d[5];
      out_d.delta_written <= s6_wr;
      out_d.rhs_adjust <= r[31:0];
    end
  end
endmodule
`default_nettype wire

// ===== design/ofc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofc_div
// Pipelined restoring divider, one quotient bit per stage, 17 quotient bits.
// ----------------------------------------------------------------------------
module ofc_div import ofc_pkg::*; #(
  parameter type tag_t = logic
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic              in_do,
  input  wire logic [OVER_W-1:0] in_num,
  input  wire logic [OSUM_W-1:0] in_den,
  input  wire logic [FRAC_W-1:0] in_frac,
  input  wire tag_t              in_tag,
  output logic                   out_valid,
  output logic [FRAC_W-1:0]      out_frac,
  output tag_t                   out_tag
);
  localparam int N = FRAC_W;
  logic [N:0]           v;
  logic [N:0]           d;
  logic [OVER_W-1:0]    rem [N+1];
  logic [OSUM_W-1:0]    den [N+1];
  logic [FRAC_W-1:0]    q   [N+1];
  tag_t                 tg  [N+1];

  always_comb begin
    v[0] = in_valid; d[0] = in_do; rem[0] = in_num; den[0] = in_den;
    q[0] = in_frac; tg[0] = in_tag;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    localparam int B = N - 1 - i;
    logic [OVER_W+N-1:0] dsh;
    logic                ge;
    assign dsh = {{(OVER_W+N-OSUM_W){1'b0}}, den[i]} << B;
    assign ge = {{N{1'b0}}, rem[i]} >= dsh;
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        d[i+1] <= d[i];
        den[i+1] <= den[i];
        tg[i+1] <= tg[i];
        if (d[i] && ge) begin
          rem[i+1] <= rem[i] - dsh[OVER_W-1:0];
          q[i+1] <= q[i] | (FRAC_W'(1) << B);
        end else begin
          rem[i+1] <= rem[i];
          q[i+1] <= q[i];
        end
      end
    end
  end

  assign out_valid = v[N];
  assign out_frac = q[N];
  assign out_tag = tg[N];
endmodule
`default_nettype wire
